// ----- rtl/core/mi3_pkg.sv -----
package mi3_pkg;

	localparam int FRAC_BITS = 16;
	localparam int IN_W      = 32;
	localparam int OUT_W     = 32;
	localparam int PROD_W    = 2 * IN_W;
	localparam int COF_W     = PROD_W + 2;
	localparam int SPLIT_W   = COF_W / 2;
	localparam int DET_W     = IN_W + COF_W + 2;
	localparam int DMAG_W    = DET_W - 1;
	localparam int NUM_W     = COF_W - 1 + 2 * FRAC_BITS;
	localparam int QB        = OUT_W + 2;
	localparam int ADJ_LAT   = 7;
	localparam int LANE_LAT  = QB + 2;
	localparam int N_LANE    = 9;

	localparam logic [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
	localparam logic [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};
	localparam logic [QB-1:0]    NEG_LIM = QB'(1) << (OUT_W - 1);
	localparam logic [QB-1:0]    POS_LIM = NEG_LIM - QB'(1);

	typedef struct packed {
		logic signed [IN_W-1:0] in_r0c0;
		logic signed [IN_W-1:0] in_r0c1;
		logic signed [IN_W-1:0] in_r0c2;
		logic signed [IN_W-1:0] in_r1c0;
		logic signed [IN_W-1:0] in_r1c1;
		logic signed [IN_W-1:0] in_r1c2;
		logic signed [IN_W-1:0] in_r2c0;
		logic signed [IN_W-1:0] in_r2c1;
		logic signed [IN_W-1:0] in_r2c2;
	} mat_t;

	typedef struct packed {
		logic signed [OUT_W-1:0] out_r0c0;
		logic signed [OUT_W-1:0] out_r0c1;
		logic signed [OUT_W-1:0] out_r0c2;
		logic signed [OUT_W-1:0] out_r1c0;
		logic signed [OUT_W-1:0] out_r1c1;
		logic signed [OUT_W-1:0] out_r1c2;
		logic signed [OUT_W-1:0] out_r2c0;
		logic signed [OUT_W-1:0] out_r2c1;
		logic signed [OUT_W-1:0] out_r2c2;
		logic                    singular;
		logic                    saturated;
	} inv_t;

	typedef struct packed {
		logic [NUM_W-1:0]  num;
		logic [DMAG_W-1:0] den;
		logic              neg;
	} lane_in_t;

	typedef struct packed {
		logic                       singular;
		lane_in_t [N_LANE-1:0]      lane;
	} adj_t;

endpackage

// ----- rtl/core/mi3_if.sv -----
interface mi3_in_if;
	logic          valid;
	logic          ready;
	mi3_pkg::mat_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface mi3_out_if;
	logic          valid;
	logic          ready;
	mi3_pkg::inv_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/core/matrix_inverse_3x3.sv -----
// Each accepted item passes the adjugate stages, nine divider lanes and output register.
// Throughput: one item per cycle unless stalled; a lane retires one quotient bit per stage.
// Back-pressure stalls the whole pipeline at once, so an item is taken whenever the
// output register is empty or being emptied in the same cycle.
// Reset clears every valid flag; data registers are not reset.
module matrix_inverse_3x3 (
	input logic       clk,
	input logic       arst_n,
	mi3_in_if.sink    matrix,
	mi3_out_if.source inverse
);

	logic                                  adv;
	logic                                  adj_vld;
	mi3_pkg::adj_t                         adj_data;
	logic signed [mi3_pkg::OUT_W-1:0]      entry [mi3_pkg::N_LANE];
	logic        [mi3_pkg::N_LANE-1:0]     sat;
	logic        [mi3_pkg::LANE_LAT-1:0]   lv_q;
	logic        [mi3_pkg::LANE_LAT-1:0]   sng_q;
	mi3_pkg::inv_t                         merged;
	logic                                  out_vld_q;
	mi3_pkg::inv_t                         out_q;

	assign adv          = !out_vld_q || inverse.ready;
	assign matrix.ready = adv;

	mi3_adj u_adj (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (matrix.valid),
		.in_data   (matrix.data),
		.out_valid (adj_vld),
		.out_data  (adj_data)
	);

	for (genvar k = 0; k < mi3_pkg::N_LANE; k++) begin : g_lane
		mi3_lane u_lane (
			.clk     (clk),
			.en      (adv),
			.in_data (adj_data.lane[k]),
			.entry   (entry[k]),
			.sat     (sat[k])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lv_q <= '0;
		end else if (adv) begin
			lv_q <= {lv_q[mi3_pkg::LANE_LAT-2:0], adj_vld};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sng_q <= {sng_q[mi3_pkg::LANE_LAT-2:0], adj_data.singular};
		end
	end

	mi3_merge u_merge (
		.singular (sng_q[mi3_pkg::LANE_LAT-1]),
		.entry    (entry),
		.sat      (sat),
		.result   (merged)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (adv) begin
			out_vld_q <= lv_q[mi3_pkg::LANE_LAT-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_q <= merged;
		end
	end

	assign inverse.valid = out_vld_q;
	assign inverse.data  = out_q;

`ifndef ASSERT_OFF
	a_singular_zero: assert property (@(posedge clk) disable iff (!arst_n)
		inverse.valid && inverse.data.singular |->
			!inverse.data.saturated && inverse.data.out_r0c0 == '0
			&& inverse.data.out_r1c1 == '0 && inverse.data.out_r2c2 == '0)
		else $error("singular result carries non-zero data");

	a_stall_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		inverse.valid && !inverse.ready |-> !matrix.ready)
		else $error("item accepted while the output is stalled");

	a_rise_needs_advance: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(inverse.valid) |-> $past(adv))
		else $error("output valid rose without the pipeline advancing");
`endif

endmodule

// ----- rtl/core/mi3_adj.sv -----
module mi3_adj (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_valid,
	input  mi3_pkg::mat_t in_data,
	output logic          out_valid,
	output mi3_pkg::adj_t out_data
);

	logic [mi3_pkg::ADJ_LAT-1:0] vld_q;

	logic signed [mi3_pkg::IN_W-1:0]                 m_s1   [3][3];
	logic signed [mi3_pkg::PROD_W-1:0]               pa_s2  [9];
	logic signed [mi3_pkg::PROD_W-1:0]               pb_s2  [9];
	logic signed [mi3_pkg::IN_W-1:0]                 m0_s2  [3];
	logic signed [mi3_pkg::COF_W-1:0]                cof_s3 [9];
	logic signed [mi3_pkg::IN_W-1:0]                 m0_s3  [3];
	logic signed [mi3_pkg::IN_W+mi3_pkg::SPLIT_W:0]   pl_s4  [3];
	logic signed [mi3_pkg::IN_W+mi3_pkg::SPLIT_W-1:0] ph_s4  [3];
	logic signed [mi3_pkg::COF_W-1:0]                cof_s4 [9];
	logic signed [mi3_pkg::DET_W-1:0]                t_s5   [3];
	logic signed [mi3_pkg::COF_W-1:0]                cof_s5 [9];
	logic signed [mi3_pkg::DET_W-1:0]                det_s6;
	logic signed [mi3_pkg::COF_W-1:0]                cof_s6 [9];

	logic                       dneg;
	logic [mi3_pkg::DET_W-1:0]  dabs;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[mi3_pkg::ADJ_LAT-2:0], in_valid};
		end
	end

	assign out_valid = vld_q[mi3_pkg::ADJ_LAT-1];

	always_ff @(posedge clk) begin
		if (en) begin
			m_s1[0][0] <= in_data.in_r0c0;
			m_s1[0][1] <= in_data.in_r0c1;
			m_s1[0][2] <= in_data.in_r0c2;
			m_s1[1][0] <= in_data.in_r1c0;
			m_s1[1][1] <= in_data.in_r1c1;
			m_s1[1][2] <= in_data.in_r1c2;
			m_s1[2][0] <= in_data.in_r2c0;
			m_s1[2][1] <= in_data.in_r2c1;
			m_s1[2][2] <= in_data.in_r2c2;
		end
	end

	for (genvar i = 0; i < 3; i++) begin : g_row
		for (genvar j = 0; j < 3; j++) begin : g_col
			localparam int P = (i + 1) % 3;
			localparam int Q = (i + 2) % 3;
			localparam int A = (j + 1) % 3;
			localparam int B = (j + 2) % 3;
			always_ff @(posedge clk) begin
				if (en) begin
					pa_s2[i*3+j]  <= m_s1[P][A] * m_s1[Q][B];
					pb_s2[i*3+j]  <= m_s1[P][B] * m_s1[Q][A];
					cof_s3[i*3+j] <= mi3_pkg::COF_W'(pa_s2[i*3+j])
						- mi3_pkg::COF_W'(pb_s2[i*3+j]);
					cof_s4[i*3+j] <= cof_s3[i*3+j];
					cof_s5[i*3+j] <= cof_s4[i*3+j];
					cof_s6[i*3+j] <= cof_s5[i*3+j];
				end
			end
		end
	end

	for (genvar j = 0; j < 3; j++) begin : g_det
		always_ff @(posedge clk) begin
			if (en) begin
				m0_s2[j] <= m_s1[0][j];
				m0_s3[j] <= m0_s2[j];
				pl_s4[j] <= m0_s3[j]
					* $signed({1'b0, cof_s3[j][mi3_pkg::SPLIT_W-1:0]});
				ph_s4[j] <= m0_s3[j]
					* $signed(cof_s3[j][mi3_pkg::COF_W-1:mi3_pkg::SPLIT_W]);
				t_s5[j]  <= (mi3_pkg::DET_W'(ph_s4[j]) <<< mi3_pkg::SPLIT_W)
					+ mi3_pkg::DET_W'(pl_s4[j]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			det_s6 <= t_s5[0] + t_s5[1] + t_s5[2];
		end
	end

	assign dneg = det_s6[mi3_pkg::DET_W-1];
	assign dabs = dneg ? -det_s6 : det_s6;

	for (genvar r = 0; r < 3; r++) begin : g_lr
		for (genvar c = 0; c < 3; c++) begin : g_lc
			logic                      cneg;
			logic [mi3_pkg::COF_W-1:0] cabs;

			assign cneg = cof_s6[c*3+r][mi3_pkg::COF_W-1];
			assign cabs = cneg ? -cof_s6[c*3+r] : cof_s6[c*3+r];

			always_ff @(posedge clk) begin
				if (en) begin
					out_data.lane[r*3+c].num <=
						mi3_pkg::NUM_W'(cabs[mi3_pkg::COF_W-2:0]) << (2 * mi3_pkg::FRAC_BITS);
					out_data.lane[r*3+c].den <= dabs[mi3_pkg::DMAG_W-1:0];
					out_data.lane[r*3+c].neg <= cneg ^ dneg;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_data.singular <= (det_s6 == '0);
		end
	end

endmodule

// ----- rtl/core/mi3_lane.sv -----
module mi3_lane (
	input  logic                           clk,
	input  logic                           en,
	input  mi3_pkg::lane_in_t              in_data,
	output logic signed [mi3_pkg::OUT_W-1:0] entry,
	output logic                           sat
);

	localparam int CMP_W = mi3_pkg::DMAG_W + mi3_pkg::QB - 1;

	logic [mi3_pkg::DMAG_W-1:0] rem_s [0:mi3_pkg::QB-1];
	logic [mi3_pkg::QB-1:0]     low_s [0:mi3_pkg::QB-1];
	logic [mi3_pkg::DMAG_W-1:0] den_s [0:mi3_pkg::QB-1];
	logic [mi3_pkg::QB-1:0]     q_s   [0:mi3_pkg::QB];
	logic                       neg_s [0:mi3_pkg::QB];
	logic                       ovf_s [0:mi3_pkg::QB];

	logic [mi3_pkg::QB:0]    q_inc;
	logic [mi3_pkg::QB-1:0]  q_rnd;
	logic                    clip;
	logic [mi3_pkg::OUT_W-1:0] mag;

	always_ff @(posedge clk) begin
		if (en) begin
			ovf_s[0] <= CMP_W'(in_data.num) >= {in_data.den, {(mi3_pkg::QB-1){1'b0}}};
			rem_s[0] <= mi3_pkg::DMAG_W'(in_data.num >> (mi3_pkg::QB - 1));
			low_s[0] <= {in_data.num[mi3_pkg::QB-2:0], 1'b0};
			den_s[0] <= in_data.den;
			neg_s[0] <= in_data.neg;
			q_s[0]   <= '0;
		end
	end

	for (genvar k = 0; k < mi3_pkg::QB; k++) begin : g_step
		logic [mi3_pkg::DMAG_W:0] trial;
		logic [mi3_pkg::DMAG_W:0] diff;
		logic                     ge;

		assign trial = {rem_s[k], low_s[k][mi3_pkg::QB-1]};
		assign ge    = trial >= {1'b0, den_s[k]};
		assign diff  = trial - {1'b0, den_s[k]};

		always_ff @(posedge clk) begin
			if (en) begin
				q_s[k+1]   <= {q_s[k][mi3_pkg::QB-2:0], ge};
				neg_s[k+1] <= neg_s[k];
				ovf_s[k+1] <= ovf_s[k];
			end
		end

		if (k < mi3_pkg::QB - 1) begin : g_carry
			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[k+1] <= ge ? diff[mi3_pkg::DMAG_W-1:0] : trial[mi3_pkg::DMAG_W-1:0];
					low_s[k+1] <= low_s[k] << 1;
					den_s[k+1] <= den_s[k];
				end
			end
		end
	end

	assign q_inc = {1'b0, q_s[mi3_pkg::QB]} + (mi3_pkg::QB+1)'(1);
	assign q_rnd = q_inc[mi3_pkg::QB:1];
	assign clip  = ovf_s[mi3_pkg::QB]
		|| (neg_s[mi3_pkg::QB] ? (q_rnd > mi3_pkg::NEG_LIM) : (q_rnd > mi3_pkg::POS_LIM));
	assign mag   = q_rnd[mi3_pkg::OUT_W-1:0];

	always_ff @(posedge clk) begin
		if (en) begin
			sat <= clip;
			if (clip) begin
				entry <= neg_s[mi3_pkg::QB] ? mi3_pkg::OUT_MIN : mi3_pkg::OUT_MAX;
			end else begin
				entry <= neg_s[mi3_pkg::QB] ? -mag : mag;
			end
		end
	end

endmodule

// ----- rtl/core/mi3_merge.sv -----
module mi3_merge (
	input  logic                             singular,
	input  logic signed [mi3_pkg::OUT_W-1:0] entry [mi3_pkg::N_LANE],
	input  logic        [mi3_pkg::N_LANE-1:0] sat,
	output mi3_pkg::inv_t                    result
);

	logic signed [mi3_pkg::OUT_W-1:0] val [mi3_pkg::N_LANE];

	for (genvar k = 0; k < mi3_pkg::N_LANE; k++) begin : g_val
		assign val[k] = singular ? '0 : entry[k];
	end

	always_comb begin
		result.out_r0c0  = val[0];
		result.out_r0c1  = val[1];
		result.out_r0c2  = val[2];
		result.out_r1c0  = val[3];
		result.out_r1c1  = val[4];
		result.out_r1c2  = val[5];
		result.out_r2c0  = val[6];
		result.out_r2c1  = val[7];
		result.out_r2c2  = val[8];
		result.singular  = singular;
		result.saturated = !singular && (|sat);
	end

endmodule
